### rtl/u2d_pkg.sv
// Shared types, constants and helper functions for the decimal ASCII converter.
package u2d_pkg;

    localparam int VALUE_W       = 32;
    localparam int DIGITS        = 10;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int COUNT_W       = 4;
    localparam int CHAR_W        = 6;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);
    localparam int DIGIT_IDX_W   = $clog2(DIGITS);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_DONE
    } front_state_t;

    // One converted value: packed BCD digits, least significant digit in the low nibble.
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [COUNT_W-1:0] count;
    } conv_t;

    // One double dabble step: correct every digit of five or more, then shift one bit in.
    function automatic logic [BCD_W-1:0] bcd_shift(input logic [BCD_W-1:0] bcd,
                                                   input logic             bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    // Number of significant digits, at least one.
    function automatic logic [COUNT_W-1:0] digit_count_of(input logic [BCD_W-1:0] bcd);
        logic [COUNT_W-1:0] cnt;
        cnt = 4'd1;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[4*i +: 4] != 4'd0) begin
                cnt = COUNT_W'(i + 1);
            end
        end
        return cnt;
    endfunction

endpackage

### rtl/u2d_front.sv
// Front end: accepts a value and converts it to BCD, four bits per cycle.
module u2d_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [u2d_pkg::VALUE_W-1:0]        value,
    output logic                               push_valid,
    input  logic                               push_ready,
    output u2d_pkg::conv_t                     push_data
);

    u2d_pkg::front_state_t             state_reg, state_next;
    logic [u2d_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [u2d_pkg::VALUE_W-1:0]       value_reg, value_next;
    logic [u2d_pkg::BCD_W-1:0]         bcd_reg, bcd_next;
    logic [u2d_pkg::BCD_W-1:0]         bcd_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= u2d_pkg::FRONT_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        bcd_reg   <= bcd_next;
    end

    // Four dependent shift-and-correct steps, taking the top bits of the value first.
    always_comb
    begin
        bcd_step = bcd_reg;
        for (int b = 0; b < u2d_pkg::BITS_PER_STEP; b++) begin
            bcd_step = u2d_pkg::bcd_shift(bcd_step, value_reg[u2d_pkg::VALUE_W-1-b]);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        value_next      = value_reg;
        bcd_next        = bcd_reg;
        in_ready        = 1'b0;
        push_valid      = 1'b0;
        push_data.bcd   = bcd_reg;
        push_data.count = u2d_pkg::digit_count_of(bcd_reg);
        unique case (state_reg)
            u2d_pkg::FRONT_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    value_next = value;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = u2d_pkg::FRONT_CONV;
                end
            end
            u2d_pkg::FRONT_CONV:
            begin
                bcd_next   = bcd_step;
                value_next = value_reg << u2d_pkg::BITS_PER_STEP;
                step_next  = step_reg + 1'b1;
                if (step_reg == u2d_pkg::STEP_W'(u2d_pkg::STEPS - 1))
                begin
                    state_next = u2d_pkg::FRONT_DONE;
                end
            end
            u2d_pkg::FRONT_DONE:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = u2d_pkg::FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = u2d_pkg::FRONT_IDLE;
            end
        endcase
    end

endmodule

### rtl/u2d_queue.sv
// Small queue of converted values between the front and back ends.
module u2d_queue
#(
    parameter int DEPTH = u2d_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  u2d_pkg::conv_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output u2d_pkg::conv_t  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2d_pkg::conv_t    mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/u2d_back.sv
// Back end: emits the digits of one converted value, most significant first.
module u2d_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  u2d_pkg::conv_t                      pop_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [u2d_pkg::CHAR_W-1:0]          ascii_char,
    output logic [u2d_pkg::COUNT_W-1:0]         digit_count,
    output logic                                last_char
);

    logic                              busy_reg, busy_next;
    logic [u2d_pkg::DIGIT_IDX_W-1:0]   idx_reg, idx_next;
    logic [u2d_pkg::BCD_W-1:0]         bcd_reg, bcd_next;
    logic [u2d_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [3:0]                        digit;
    logic                              out_done;

    assign digit       = bcd_reg[4*idx_reg +: 4];
    assign out_valid   = busy_reg;
    assign ascii_char  = u2d_pkg::ASCII_ZERO + u2d_pkg::CHAR_W'(digit);
    assign digit_count = count_reg;
    assign last_char   = (idx_reg == '0);
    assign out_done    = out_valid && out_ready;

    // A new value is taken as soon as the last digit of the current one leaves.
    assign pop_ready = !busy_reg || (out_done && last_char);

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        if (out_done && !last_char)
        begin
            idx_next = idx_reg - 1'b1;
        end
        if (pop_ready)
        begin
            busy_next = pop_valid;
            if (pop_valid)
            begin
                bcd_next   = pop_data.bcd;
                count_next = pop_data.count;
                idx_next   = u2d_pkg::DIGIT_IDX_W'(pop_data.count - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        count_reg <= count_next;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (u2d_pkg::COUNT_W'(idx_reg) < count_reg))
        else $error("digit index beyond digit count");

    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (digit <= 4'd9))
        else $error("emitted digit is not decimal");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> (busy_reg && u2d_pkg::COUNT_W'(idx_reg) == count_reg - 1'b1))
        else $error("new value not loaded at its top digit");

endmodule

### rtl/uint32_to_decimal_ascii.sv
// Top level: 32-bit unsigned to decimal ASCII characters, most significant digit first.
// Path: a value passes through 8 BCD steps of four bits in the front end, a push into the
// queue and a load into the back end before its first character is output.
// Throughput: one character per cycle in the back end while out_ready is high; a value holds
// the back end until its last digit leaves, and the front end takes no new value until the current one is pushed.
// Reset: rst_n clears all control state asynchronously; no clearing pass is needed.
module uint32_to_decimal_ascii
#(
    parameter int QUEUE_DEPTH = u2d_pkg::QUEUE_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [u2d_pkg::VALUE_W-1:0]         value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [u2d_pkg::CHAR_W-1:0]          ascii_char,
    output logic [u2d_pkg::COUNT_W-1:0]         digit_count,
    output logic                                last_char
);

    logic            push_valid, push_ready;
    logic            pop_valid, pop_ready;
    u2d_pkg::conv_t  push_data, pop_data;

    u2d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    u2d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    u2d_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ascii_char  (ascii_char),
        .digit_count (digit_count),
        .last_char   (last_char)
    );

endmodule
